@@ design/ssct_pkg.sv @@
// ----------------------------------------------------------------------------
// ssct_pkg
// Shared types, widths and codes of the swept sphere collision test.
// ----------------------------------------------------------------------------
package ssct_pkg;

	localparam int COORD_W  = 16;
	localparam int RADIUS_W = COORD_W - 1;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int LIMB_W   = 18;
	localparam int WIDE_W   = 2 * LIMB_W;
	localparam int LEN_W    = 2 * DIFF_W;
	localparam int ACC_W    = 4 * LIMB_W;
	localparam int RSQ_W    = 2 * COORD_W;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 8;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

	typedef enum logic [1:0] {
		PATH_NONE   = 2'd0,
		PATH_BEHIND = 2'd1,
		PATH_ALONG  = 2'd2,
		PATH_PAST   = 2'd3
	} path_t;

	typedef struct packed {
		logic                is_test;
		coord_t [2:0]        old_pos;
		coord_t [2:0]        new_pos;
		logic [RADIUS_W-1:0] radius;
	} item_t;

	typedef struct packed {
		logic  collision;
		logic  overlap_now;
		logic  swept_hit;
		logic  mover_second;
		path_t path_case;
	} result_t;

	function automatic logic [LIMB_W-1:0] mag_of(diff_t v);
		logic signed [LIMB_W-1:0] ext;
		ext = LIMB_W'(v);
		return v[DIFF_W-1] ? LIMB_W'(-ext) : LIMB_W'(ext);
	endfunction

	function automatic logic [LIMB_W-1:0] limb_of(logic [WIDE_W-1:0] x, logic hi);
		return hi ? x[WIDE_W-1:LIMB_W] : x[LIMB_W-1:0];
	endfunction

endpackage

@@ design/ssct_front.sv @@
// ----------------------------------------------------------------------------
// ssct_front
// Input side: takes stream words, tracks whether a first sphere is held and
// forwards loads and valid tests to the queue; drops orphan second spheres.
// ----------------------------------------------------------------------------
module ssct_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ssct_pkg::IN_DATA_W-1:0]  in_data,
	input  logic                            in_slot,
	output logic                            push,
	output ssct_pkg::item_t                 push_item,
	input  logic                            q_full
);
	import ssct_pkg::*;

	logic held_q;
	logic take;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign push     = take && (!in_slot || held_q);

	always_comb begin
		push_item.is_test    = in_slot;
		push_item.old_pos[0] = in_data[15:0];
		push_item.old_pos[1] = in_data[31:16];
		push_item.old_pos[2] = in_data[47:32];
		push_item.new_pos[0] = in_data[63:48];
		push_item.new_pos[1] = in_data[79:64];
		push_item.new_pos[2] = in_data[95:80];
		push_item.radius     = in_data[110:96];
	end

	// a first sphere arms the pair, a second one consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (take) begin
			held_q <= !in_slot;
		end
	end

endmodule

@@ design/ssct_queue.sv @@
// ----------------------------------------------------------------------------
// ssct_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module ssct_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ssct_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output ssct_pkg::item_t head
);
	import ssct_pkg::*;

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ design/ssct_back.sv @@
// ----------------------------------------------------------------------------
// ssct_back
// Execution side: holds the first sphere and runs each test through one
// shared 18x18 multiply-accumulate unit, then parks the result.
// ----------------------------------------------------------------------------
module ssct_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_not_empty,
	input  ssct_pkg::item_t   q_head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output ssct_pkg::result_t out_res
);
	import ssct_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE = 12'h001,
		S_RSQ  = 12'h002,
		S_CUR  = 12'h004,
		S_L1   = 12'h008,
		S_L2   = 12'h010,
		S_DW   = 12'h020,
		S_DV   = 12'h040,
		S_LEN  = 12'h080,
		S_PRA  = 12'h100,
		S_PRB  = 12'h200,
		S_PRC  = 12'h400,
		S_OUT  = 12'h800
	} state_t;

	state_t state_q;
	logic [1:0] k_q;

	coord_t [2:0] ho_q, hn_q, op_q, np_q;
	logic [RADIUS_W-1:0] hr_q, rad_q;
	diff_t [2:0] u_q, w_q, v_q;
	diff_t [2:0] cur, m1, m2;

	logic [RSQ_W-1:0] rsq_q;
	logic [LEN_W-1:0] l1_q, lu_q, lw_q, proj_q;
	logic signed [ACC_W-1:0] acc_q, acc_nxt;
	logic ov_q, sw_q, sec_q, len_v_q;
	path_t path_q;
	result_t res_q;
	logic out_valid_q;

	logic [LIMB_W-1:0] ma, mb;
	logic neg, clear, last;
	logic [1:0] shn;
	diff_t ea, eb;
	logic [WIDE_W-1:0] prod;
	logic [ACC_W-1:0] term;
	logic [COORD_W-1:0] rsum;
	logic [LEN_W-1:0] len_now;

	for (genvar i = 0; i < 3; i++) begin : g_diff
		assign cur[i] = DIFF_W'(np_q[i]) - DIFF_W'(hn_q[i]);
		assign m1[i]  = DIFF_W'(hn_q[i]) - DIFF_W'(ho_q[i]);
		assign m2[i]  = DIFF_W'(np_q[i]) - DIFF_W'(op_q[i]);
	end

	assign rsum    = COORD_W'(hr_q) + COORD_W'(rad_q);
	assign pop     = (state_q == S_IDLE) && q_not_empty;
	assign len_now = acc_nxt[LEN_W-1:0];

	// operand selection for the shared multiplier
	always_comb begin
		ea  = '0;
		eb  = '0;
		ma  = '0;
		mb  = '0;
		neg = 1'b0;
		shn = 2'd0;
		case (state_q)
			S_CUR: begin ea = cur[k_q]; eb = cur[k_q]; end
			S_L1:  begin ea = m1[k_q];  eb = m1[k_q];  end
			S_L2:  begin ea = m2[k_q];  eb = m2[k_q];  end
			S_DW:  begin ea = u_q[k_q]; eb = w_q[k_q]; end
			S_DV:  begin ea = u_q[k_q]; eb = v_q[k_q]; end
			S_LEN: begin
				ea = len_v_q ? v_q[k_q] : w_q[k_q];
				eb = ea;
			end
			default: begin end
		endcase
		case (state_q)
			S_RSQ: begin
				ma = LIMB_W'(rsum);
				mb = LIMB_W'(rsum);
			end
			S_PRA: begin
				ma = limb_of(WIDE_W'(lw_q), k_q[1]);
				mb = limb_of(WIDE_W'(lu_q), k_q[0]);
				shn = 2'(k_q[1]) + 2'(k_q[0]);
			end
			S_PRB: begin
				ma = limb_of(WIDE_W'(proj_q), k_q[1]);
				mb = limb_of(WIDE_W'(proj_q), k_q[0]);
				shn = 2'(k_q[1]) + 2'(k_q[0]);
				neg = 1'b1;
			end
			S_PRC: begin
				ma = limb_of(WIDE_W'(rsq_q), k_q[1]);
				mb = limb_of(WIDE_W'(lu_q), k_q[0]);
				shn = 2'(k_q[1]) + 2'(k_q[0]);
				neg = 1'b1;
			end
			default: begin
				ma  = mag_of(ea);
				mb  = mag_of(eb);
				neg = ea[DIFF_W-1] ^ eb[DIFF_W-1];
			end
		endcase
	end

	always_comb begin
		prod    = ma * mb;
		term    = ACC_W'(prod) << (LIMB_W * shn);
		clear   = (k_q == 2'd0) && (state_q != S_PRB) && (state_q != S_PRC);
		acc_nxt = (clear ? '0 : acc_q) + (neg ? -$signed(term) : $signed(term));
		case (state_q)
			S_RSQ:                 last = 1'b1;
			S_PRA, S_PRB, S_PRC:   last = (k_q == 2'd3);
			default:               last = (k_q == 2'd2);
		endcase
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_nxt;
		if (pop && !q_head.is_test) begin
			ho_q <= q_head.old_pos;
			hn_q <= q_head.new_pos;
			hr_q <= q_head.radius;
		end
		if (pop && q_head.is_test) begin
			op_q  <= q_head.old_pos;
			np_q  <= q_head.new_pos;
			rad_q <= q_head.radius;
		end
		if (last) begin
			case (state_q)
				S_RSQ: rsq_q <= acc_nxt[RSQ_W-1:0];
				S_CUR: ov_q  <= len_now < LEN_W'(rsq_q);
				S_L1:  l1_q  <= len_now;
				S_L2: begin
					// a tie or no motion at all leaves the first sphere as mover
					sec_q <= l1_q < len_now;
					lu_q  <= (l1_q < len_now) ? len_now : l1_q;
					for (int i = 0; i < 3; i++) begin
						if (l1_q < len_now) begin
							u_q[i] <= m2[i];
							w_q[i] <= DIFF_W'(hn_q[i]) - DIFF_W'(op_q[i]);
							v_q[i] <= DIFF_W'(hn_q[i]) - DIFF_W'(np_q[i]);
						end else begin
							u_q[i] <= m1[i];
							w_q[i] <= DIFF_W'(np_q[i]) - DIFF_W'(ho_q[i]);
							v_q[i] <= DIFF_W'(np_q[i]) - DIFF_W'(hn_q[i]);
						end
					end
					if (l1_q == '0 && len_now == '0) begin
						sw_q   <= 1'b0;
						path_q <= PATH_NONE;
					end
				end
				S_DW: begin
					proj_q  <= len_now;
					len_v_q <= 1'b0;
					if (acc_nxt < 0) path_q <= PATH_BEHIND;
				end
				S_DV: begin
					len_v_q <= !(acc_nxt < 0);
					path_q  <= (acc_nxt < 0) ? PATH_ALONG : PATH_PAST;
				end
				S_LEN: begin
					lw_q <= len_now;
					sw_q <= len_now <= LEN_W'(rsq_q);
				end
				S_PRC: sw_q <= !(acc_nxt > 0);
				default: begin end
			endcase
		end
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			res_q.collision    <= ov_q || sw_q;
			res_q.overlap_now  <= ov_q;
			res_q.swept_hit    <= sw_q;
			res_q.mover_second <= sec_q;
			res_q.path_case    <= path_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_IDLE || state_q == S_OUT) begin
				k_q <= 2'd0;
			end else begin
				k_q <= last ? 2'd0 : k_q + 2'd1;
			end
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (pop && q_head.is_test) state_q <= S_RSQ;
				S_RSQ: state_q <= S_CUR;
				S_CUR: if (last) state_q <= S_L1;
				S_L1:  if (last) state_q <= S_L2;
				S_L2:  if (last) state_q <= (l1_q == '0 && len_now == '0) ? S_OUT : S_DW;
				S_DW:  if (last) state_q <= (acc_nxt < 0) ? S_LEN : S_DV;
				S_DV:  if (last) state_q <= S_LEN;
				S_LEN: if (last) state_q <= (path_q == PATH_ALONG) ? S_PRA : S_OUT;
				S_PRA: if (last) state_q <= S_PRB;
				S_PRB: if (last) state_q <= S_PRC;
				S_PRC: if (last) state_q <= S_OUT;
				S_OUT: if (!out_valid_q || out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

@@ design/swept_sphere_collision_test_top.sv @@
// ----------------------------------------------------------------------------
// swept_sphere_collision_test_top
// Overlap and swept-path collision test for a pair of spheres.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_axis group, one sphere per word. tuser is
//   the slot: 0 loads the first sphere of a pair, 1 runs the test against
//   the held sphere and yields one result word on m_axis. A slot 1 word with
//   no sphere held is dropped; a repeated slot 0 word replaces the held one.
//   The front takes words into a two-entry queue; the back drains it and
//   works one test at a time through a single 18x18 multiply-accumulate.
// Timing:
//   A load is taken while the back is idle. A test takes least time with no
//   motion, more when the nearest point is behind the start, more again when
//   it is past the end and most when it lies along the path; the multiplier
//   steps (one square or product term per cycle) set this.
// Reset:
//   arst_n empties the queue and clears the held-sphere flag and output valid.
// Stall:
//   A result waits in the output register; the back carries on with the
//   next test and holds it finished until that register frees, while the
//   queue fills and then drops s_axis_tready.
// ----------------------------------------------------------------------------
module swept_sphere_collision_test_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// old_x, old_y, old_z, new_x, new_y, new_z, radius, zero pad
	input  logic [ssct_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// sphere_slot
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// collision, overlap_now, swept_hit, mover_second, path_case[1:0], zero pad
	output logic [ssct_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import ssct_pkg::*;

	logic    push, q_full, q_not_empty, pop;
	item_t   push_item, q_head;
	result_t res;

	ssct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_slot   (s_axis_tuser),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	ssct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	ssct_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_res     (res)
	);

	// pack the result word, collision in the lowest bit
	assign m_axis_tdata = {2'b00, res.path_case, res.mover_second, res.swept_hit,
		res.overlap_now, res.collision};

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full && !pop))
		else $error("queue written while full");

	a_collision_or: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[1] || m_axis_tdata[2])))
		else $error("collision flag not the OR of the two tests");

	a_still_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[5:4] == PATH_NONE)
		|-> (!m_axis_tdata[2] && !m_axis_tdata[3]))
		else $error("swept result without motion");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_not_empty)
		else $error("queue read while empty");
`endif

endmodule

@@ tb/ssct_checker.sv @@
// ----------------------------------------------------------------------------
// ssct_checker
// Watches both stream channels, predicts each pair's collision result and
// compares it as a whole word with the words leaving the block.
// ----------------------------------------------------------------------------
module ssct_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [ssct_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                            s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [ssct_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output int                              fail_count,
	output int                              pending,
	output int                              result_count
);
	import ssct_pkg::*;

	typedef logic signed [39:0] sq_t;
	typedef logic signed [95:0] huge_t;

	coord_t             keep_old [3];
	coord_t             keep_new [3];
	logic [RADIUS_W-1:0] keep_rad;
	logic               keep_valid;
	result_t            expected_q [$];

	function automatic sq_t len_sq(sq_t a0, sq_t a1, sq_t a2);
		return a0 * a0 + a1 * a1 + a2 * a2;
	endfunction

	// exact collision verdict for the held sphere and the incoming one
	function automatic result_t collide(coord_t op [3], coord_t np [3],
			logic [RADIUS_W-1:0] rad);
		result_t r;
		sq_t     cur [3], m1 [3], m2 [3], u [3], w [3], v [3];
		sq_t     rsum, rsq, l1, l2, lu, uw, uv;
		huge_t   lhs, rhs;
		logic    second;
		rsum = sq_t'(keep_rad) + sq_t'(rad);
		rsq  = rsum * rsum;
		for (int i = 0; i < 3; i++) begin
			cur[i] = sq_t'(np[i]) - sq_t'(keep_new[i]);
			m1[i]  = sq_t'(keep_new[i]) - sq_t'(keep_old[i]);
			m2[i]  = sq_t'(np[i]) - sq_t'(op[i]);
		end
		r = '0;
		r.overlap_now = len_sq(cur[0], cur[1], cur[2]) < rsq;
		r.path_case = PATH_NONE;
		l1 = len_sq(m1[0], m1[1], m1[2]);
		l2 = len_sq(m2[0], m2[1], m2[2]);
		if (l1 != 0 || l2 != 0) begin
			second = l1 < l2;
			r.mover_second = second;
			lu = second ? l2 : l1;
			for (int i = 0; i < 3; i++) begin
				u[i] = second ? m2[i] : m1[i];
				w[i] = second ? sq_t'(keep_new[i]) - sq_t'(op[i])
				              : sq_t'(np[i]) - sq_t'(keep_old[i]);
				v[i] = second ? sq_t'(keep_new[i]) - sq_t'(np[i])
				              : sq_t'(np[i]) - sq_t'(keep_new[i]);
			end
			uw = u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
			uv = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
			if (uw < 0) begin
				r.path_case = PATH_BEHIND;
				r.swept_hit = len_sq(w[0], w[1], w[2]) <= rsq;
			end else if (uv < 0) begin
				r.path_case = PATH_ALONG;
				lhs = huge_t'(len_sq(w[0], w[1], w[2])) * huge_t'(lu);
				rhs = huge_t'(rsq) * huge_t'(lu) + huge_t'(uw) * huge_t'(uw);
				r.swept_hit = lhs <= rhs;
			end else begin
				r.path_case = PATH_PAST;
				r.swept_hit = len_sq(v[0], v[1], v[2]) <= rsq;
			end
		end
		r.collision = r.overlap_now | r.swept_hit;
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		coord_t  op [3], np [3];
		result_t want;
		logic [OUT_DATA_W-1:0] want_word;
		if (!arst_n) begin
			keep_valid   <= 1'b0;
			keep_rad     <= '0;
			fail_count   <= 0;
			result_count <= 0;
			for (int i = 0; i < 3; i++) begin
				keep_old[i] <= '0;
				keep_new[i] <= '0;
			end
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				for (int i = 0; i < 3; i++) begin
					op[i] = s_axis_tdata[16*i +: 16];
					np[i] = s_axis_tdata[48 + 16*i +: 16];
				end
				if (!s_axis_tuser) begin
					keep_old   <= op;
					keep_new   <= np;
					keep_rad   <= s_axis_tdata[96 +: RADIUS_W];
					keep_valid <= 1'b1;
				end else if (keep_valid) begin
					expected_q.push_back(collide(op, np, s_axis_tdata[96 +: RADIUS_W]));
					keep_valid <= 1'b0;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				result_count <= result_count + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					// pack as on the wire, collision in the lowest bit
					want_word = {2'b00, want.path_case, want.mover_second,
						want.swept_hit, want.overlap_now, want.collision};
					if (m_axis_tdata !== want_word) begin
						$display("%0t: mismatch expected %b actual %b", $time, want_word,
							m_axis_tdata);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

@@ tb/tb_swept_sphere_collision_test_top.sv @@
// ----------------------------------------------------------------------------
// tb_swept_sphere_collision_test_top
// Drives directed and random sphere pairs into the collision block under
// changing sender and receiver idling, including a long output hold-off,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_swept_sphere_collision_test_top;
	import ssct_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	int                    fail_count, pending, result_count;
	int                    send_idle_pct, recv_idle_pct;
	logic                  hold_req;
	int                    hold_cnt;
	longint                cycle = 0;

	swept_sphere_collision_test_top dut (.*);

	ssct_checker chk (.*);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hard stop well beyond the slowest legal run
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 400000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_cnt      <= 0;
		end else if (hold_req && hold_cnt < 400) begin
			m_axis_tready <= 1'b0;
			hold_cnt      <= hold_cnt + 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// offer one word; hold it until taken, with random gaps before it
	task automatic send_word(logic slot, coord_t op [3], coord_t np [3],
			logic [RADIUS_W-1:0] rad);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= slot;
		s_axis_tdata  <= {1'b0, rad, np[2], np[1], np[0], op[2], op[1], op[0]};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic coord_t rnd_coord(int span);
		case ($urandom_range(5))
			0:       return coord_t'($urandom);
			1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return coord_t'($signed($urandom_range(2 * span)) - span);
		endcase
	endfunction

	task automatic rnd_sphere(logic slot, coord_t base [3], int span);
		coord_t op [3], np [3];
		logic [RADIUS_W-1:0] rad;
		for (int i = 0; i < 3; i++) begin
			np[i] = base[i] + rnd_coord(span);
			op[i] = ($urandom_range(4) == 0) ? np[i] : np[i] + rnd_coord(span);
		end
		case ($urandom_range(3))
			0:       rad = RADIUS_W'($urandom);
			1:       rad = $urandom_range(1) ? '1 : '0;
			default: rad = RADIUS_W'($urandom_range(span));
		endcase
		send_word(slot, op, np, rad);
	endtask

	task automatic rnd_phase(int n);
		coord_t base [3];
		int span;
		for (int k = 0; k < n; k++) begin
			span = $urandom_range(1) ? 300 : 4000;
			for (int i = 0; i < 3; i++) base[i] = coord_t'($urandom);
			case ($urandom_range(9))
				0: rnd_sphere(1'b1, base, span);  // second sphere, stray unless a first is held
				1: rnd_sphere(1'b0, base, span);  // lone first, maybe replaced
				default: begin
					rnd_sphere(1'b0, base, span);
					rnd_sphere(1'b1, base, span);
				end
			endcase
		end
	endtask

	initial begin
		coord_t z [3], a [3], b [3], c [3], mx [3], mn [3];
		hold_req      = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = 1'b0;
		s_axis_tdata  = '0;
		send_idle_pct = 22;
		recv_idle_pct = 73;
		z  = '{16'sd0, 16'sd0, 16'sd0};
		mx = '{16'sh7fff, 16'sh7fff, 16'sh7fff};
		mn = '{16'sh8000, 16'sh8000, 16'sh8000};
		a  = '{16'sd0, 16'sd0, 16'sd0};
		b  = '{16'sd1000, 16'sd0, 16'sd0};
		c  = '{16'sd500, 16'sd100, 16'sd0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray second, no motion, each path case, extremes
		send_word(1'b1, z, z, 15'd10);
		send_word(1'b0, z, z, 15'd0);
		send_word(1'b1, z, z, 15'd0);
		send_word(1'b0, a, b, 15'd50);
		send_word(1'b1, c, c, 15'd60);        // along the path
		send_word(1'b0, a, b, 15'd50);
		send_word(1'b1, '{-16'sd200, 16'sd0, 16'sd0}, '{-16'sd200, 16'sd0, 16'sd0}, 15'd60);
		send_word(1'b0, a, b, 15'd50);
		send_word(1'b1, '{16'sd1200, 16'sd0, 16'sd0}, '{16'sd1200, 16'sd0, 16'sd0}, 15'd60);
		send_word(1'b0, c, c, 15'd10);
		send_word(1'b1, a, b, 15'd20);        // second sphere moves
		send_word(1'b0, mn, mx, 15'h7fff);
		send_word(1'b0, mx, mn, 15'h7fff);    // replaces the held sphere
		send_word(1'b1, mn, mx, 15'h7fff);
		send_word(1'b0, mx, mn, 15'd0);
		send_word(1'b1, mx, mn, 15'h7fff);
		send_word(1'b0, a, b, 15'd1);
		send_word(1'b1, b, a, 15'd1);         // equal motion, tie to the first
		s_axis_tvalid <= 1'b0;

		rnd_phase(150);
		// long receiver hold-off while the sender keeps offering
		hold_req = 1'b1;
		send_idle_pct = 0;
		rnd_phase(60);
		send_idle_pct = 73;
		recv_idle_pct = 22;
		rnd_phase(140);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rnd_phase(140);
		s_axis_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ files.f @@
design/ssct_pkg.sv
design/ssct_front.sv
design/ssct_queue.sv
design/ssct_back.sv
design/swept_sphere_collision_test_top.sv
tb/ssct_checker.sv
tb/tb_swept_sphere_collision_test_top.sv
